// ===== sv/cawbs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the conditional ALU with barrel shifter.
// Holds the operation and condition codes, shift types and the decoded item type.
package cawbs_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_RSB = 4'd3,
    OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_RSC = 4'd7,
    OP_CMP = 4'd8, OP_CMN = 4'd9, OP_ORR = 4'd10, OP_MOV = 4'd11,
    OP_BIC = 4'd12, OP_MVN = 4'd13, OP_B = 4'd14, OP_BL = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0, CC_NE = 4'd1, CC_CS = 4'd2, CC_CC = 4'd3,
    CC_MI = 4'd4, CC_PL = 4'd5, CC_VS = 4'd6, CC_VC = 4'd7,
    CC_HI = 4'd8, CC_LS = 4'd9, CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_t;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [3:0] LINK_REG = 4'd14;

  // Decoded item handed from the front end to the execute side.
  typedef struct packed {
    op_t         op;
    cond_t       cond;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [3:0]  rs;
    logic        imm;
    logic        flag_update;
    logic        reg_amt;
    logic [1:0]  sh_type;
    logic [4:0]  sh_imm;
    logic [3:0]  rot;
    logic [7:0]  imm8;
    logic        is_branch;
    logic        is_link;
    logic        is_cmp;
    logic        is_logical;
    logic [31:0] link_value;
    logic [31:0] target;
  } item_t;

endpackage

// ===== sv/cawbs_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input items and classifies them into decoded items.
// Depends on cawbs_pkg.
module cawbs_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         operation,
  input  logic [3:0]         cond,
  input  logic [3:0]         rd,
  input  logic [3:0]         rn,
  input  logic [11:0]        operand2,
  input  logic               imm_flag,
  input  logic               flag_update,
  input  logic signed [23:0] branch_offset,
  input  logic [31:0]        instr_address,
  input  logic               q_full,
  output logic               push,
  output cawbs_pkg::item_t   item
);
  import cawbs_pkg::*;

  logic [31:0] link;
  op_t         op;

  assign op       = op_t'(operation);
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign link     = instr_address + 32'd4;

  always_comb begin
    item             = '0;
    item.op          = op;
    item.cond        = cond_t'(cond);
    item.rd          = rd;
    item.rn          = rn;
    item.rm          = operand2[3:0];
    item.rs          = operand2[11:8];
    item.imm         = imm_flag;
    item.flag_update = flag_update;
    item.reg_amt     = operand2[4];
    item.sh_type     = operand2[6:5];
    item.sh_imm      = operand2[11:7];
    item.rot         = operand2[11:8];
    item.imm8        = operand2[7:0];
    item.is_branch   = (op == OP_B) || (op == OP_BL);
    item.is_link     = (op == OP_BL);
    item.is_cmp      = (op == OP_CMP) || (op == OP_CMN);
    item.is_logical  = (op inside {OP_AND, OP_EOR, OP_ORR, OP_MOV, OP_BIC, OP_MVN});
    item.link_value  = link;
    item.target      = link + {{6{branch_offset[23]}}, branch_offset, 2'b00};
  end

endmodule

// ===== sv/cawbs_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of decoded items between the front end and the execute side.
// Depends on cawbs_pkg.
module cawbs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cawbs_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output cawbs_pkg::item_t head
);
  import cawbs_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/cawbs_back.sv =====
`timescale 1ns / 1ps
// Execute side: register read stage, shifter, ALU, flags and the output register.
// Depends on cawbs_pkg.
module cawbs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cawbs_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             executed,
  output logic             reg_write,
  output logic [3:0]       dest_reg,
  output logic [31:0]      write_value,
  output logic [3:0]       flags_out,
  output logic             branch_taken,
  output logic [31:0]      branch_target
);
  import cawbs_pkg::*;

  // Three copies of the register file, one per read address.
  logic [31:0] mem_a [16];
  logic [31:0] mem_m [16];
  logic [31:0] mem_s [16];
  logic [15:0] written;

  logic        r_valid;
  item_t       r_item;
  logic [31:0] rd_a_q, rd_m_q, rd_s_q;
  logic        vld_a_q, vld_m_q, vld_s_q;
  logic        fwd_a_q, fwd_m_q, fwd_s_q;
  logic [31:0] fwd_val_q;
  logic [3:0]  flags;

  logic        fire, load;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic [31:0] a_val, m_val, s_val;
  logic        pass, cin, sc;
  logic [31:0] b_val, res;
  logic [31:0] x, y;
  logic        ci;
  logic [32:0] sum;
  logic        c_new, v_new, upd, wrt;
  logic [3:0]  flags_new;
  logic [7:0]  amt;

  assign fire  = r_valid && (!out_valid || out_ready);
  assign load  = q_valid && (!r_valid || fire);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_m[waddr] <= wdata;
      mem_s[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rd_a_q    <= mem_a[q_item.rn];
      rd_m_q    <= mem_m[q_item.rm];
      rd_s_q    <= mem_s[q_item.rs];
      r_item    <= q_item;
      vld_a_q   <= written[q_item.rn];
      vld_m_q   <= written[q_item.rm];
      vld_s_q   <= written[q_item.rs];
      fwd_a_q   <= we && (waddr == q_item.rn);
      fwd_m_q   <= we && (waddr == q_item.rm);
      fwd_s_q   <= we && (waddr == q_item.rs);
      fwd_val_q <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      r_valid <= 1'b0;
      flags   <= 4'd0;
    end else begin
      if (we) written[waddr] <= 1'b1;
      if (load) r_valid <= 1'b1;
      else if (fire) r_valid <= 1'b0;
      if (fire) flags <= flags_new;
    end
  end

  assign a_val = fwd_a_q ? fwd_val_q : (vld_a_q ? rd_a_q : 32'd0);
  assign m_val = fwd_m_q ? fwd_val_q : (vld_m_q ? rd_m_q : 32'd0);
  assign s_val = fwd_s_q ? fwd_val_q : (vld_s_q ? rd_s_q : 32'd0);
  assign cin   = flags[1];

  always_comb begin
    case (r_item.cond)
      CC_EQ:   pass = flags[2];
      CC_NE:   pass = !flags[2];
      CC_CS:   pass = flags[1];
      CC_CC:   pass = !flags[1];
      CC_MI:   pass = flags[3];
      CC_PL:   pass = !flags[3];
      CC_VS:   pass = flags[0];
      CC_VC:   pass = !flags[0];
      CC_HI:   pass = flags[1] && !flags[2];
      CC_LS:   pass = !flags[1] || flags[2];
      CC_GE:   pass = (flags[3] == flags[0]);
      CC_LT:   pass = (flags[3] != flags[0]);
      CC_GT:   pass = !flags[2] && (flags[3] == flags[0]);
      CC_LE:   pass = flags[2] || (flags[3] != flags[0]);
      default: pass = 1'b1;
    endcase
  end

  // Barrel shifter.
  always_comb begin
    logic [32:0] wide;
    logic [63:0] dbl;
    logic [4:0]  rot2;
    wide  = '0;
    dbl   = '0;
    rot2  = {r_item.rot, 1'b0};
    amt   = r_item.reg_amt ? s_val[7:0] : {3'd0, r_item.sh_imm};
    b_val = m_val;
    sc    = cin;
    if (r_item.imm) begin
      dbl   = {24'd0, r_item.imm8, 24'd0, r_item.imm8} >> rot2;
      b_val = dbl[31:0];
      sc    = (rot2 == 5'd0) ? cin : b_val[31];
    end else if (!r_item.reg_amt && r_item.sh_imm == 5'd0 && r_item.sh_type == SH_ROR) begin
      b_val = {cin, m_val[31:1]};
      sc    = m_val[0];
    end else begin
      if (!r_item.reg_amt && r_item.sh_imm == 5'd0 && r_item.sh_type != SH_LSL) begin
        amt = 8'd32;
      end
      if (amt != 8'd0) begin
        case (r_item.sh_type)
          SH_LSL: begin
            wide  = {1'b0, m_val} << amt[4:0];
            b_val = (amt < 8'd32) ? wide[31:0] : 32'd0;
            sc    = (amt < 8'd32) ? wide[32] : ((amt == 8'd32) ? m_val[0] : 1'b0);
          end
          SH_LSR: begin
            wide  = {m_val, 1'b0} >> amt[4:0];
            b_val = (amt < 8'd32) ? wide[32:1] : 32'd0;
            sc    = (amt < 8'd32) ? wide[0] : ((amt == 8'd32) ? m_val[31] : 1'b0);
          end
          SH_ASR: begin
            wide  = 33'($signed({m_val, 1'b0}) >>> amt[4:0]);
            b_val = (amt < 8'd32) ? wide[32:1] : {32{m_val[31]}};
            sc    = (amt < 8'd32) ? wide[0] : m_val[31];
          end
          default: begin
            dbl   = {m_val, m_val} >> amt[4:0];
            b_val = dbl[31:0];
            sc    = b_val[31];
          end
        endcase
      end
    end
  end

  // Adder operand selection and logical results.
  always_comb begin
    x  = a_val;
    y  = b_val;
    ci = 1'b0;
    case (r_item.op)
      OP_SUB, OP_CMP: begin y = ~b_val; ci = 1'b1; end
      OP_RSB:         begin x = b_val; y = ~a_val; ci = 1'b1; end
      OP_ADC:         ci = cin;
      OP_SBC:         begin y = ~b_val; ci = cin; end
      OP_RSC:         begin x = b_val; y = ~a_val; ci = cin; end
      default:        ci = 1'b0;
    endcase
    sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
    case (r_item.op)
      OP_AND:  res = a_val & b_val;
      OP_EOR:  res = a_val ^ b_val;
      OP_ORR:  res = a_val | b_val;
      OP_MOV:  res = b_val;
      OP_BIC:  res = a_val & ~b_val;
      OP_MVN:  res = ~b_val;
      default: res = sum[31:0];
    endcase
    c_new = r_item.is_logical ? sc : sum[32];
    v_new = r_item.is_logical ? flags[0] : ((~(x[31] ^ y[31])) & (x[31] ^ sum[31]));
    upd   = pass && !r_item.is_branch && (r_item.flag_update || r_item.is_cmp);
    flags_new = upd ? {res[31], (res == 32'd0), c_new, v_new} : flags;
    wrt   = pass && !r_item.is_cmp && (!r_item.is_branch || r_item.is_link);
    waddr = r_item.is_branch ? LINK_REG : r_item.rd;
    wdata = r_item.is_branch ? r_item.link_value : res;
  end

  assign we = fire && wrt;

  always_ff @(posedge clk) begin
    if (fire) begin
      executed      <= pass;
      reg_write     <= wrt;
      dest_reg      <= wrt ? waddr : 4'd0;
      write_value   <= wrt ? wdata : 32'd0;
      flags_out     <= flags_new;
      branch_taken  <= pass && r_item.is_branch;
      branch_target <= (pass && r_item.is_branch) ? r_item.target : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_fire_out: assert property (@(posedge clk) disable iff (rst) fire |=> out_valid)
    else $error("executed item did not reach the output register");
  a_branch_exec: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken |-> executed)
    else $error("branch taken without execution");
  a_link_reg: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken && reg_write |-> dest_reg == LINK_REG)
    else $error("branch wrote a register other than the link register");
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_write |-> dest_reg == 4'd0 && write_value == 32'd0)
    else $error("write fields set without a register write");

endmodule

// ===== sv/conditional_alu_with_barrel_shifter.sv =====
`timescale 1ns / 1ps
// Conditional ALU with barrel shifter, top level.
// Depends on cawbs_pkg, cawbs_front, cawbs_queue and cawbs_back.
//
// This block executes one ARM-style data-processing or branch instruction per
// input item against a sixteen-entry register file and an NZCV flag register,
// both cleared by reset, and returns exactly one result item per input item.
// It sustains one item per clock cycle while the output is not stalled: the
// front end classifies each item and places it in a two-entry queue, the
// execute side reads the three source registers into a read stage and then
// shifts, adds and updates state, writing the result into an output register.
// A new item is taken while a finished result still waits in the output
// register, and the queue lets the input side keep accepting during short
// output stalls. Register reads see the write of the item just ahead through a
// forwarding path, so back-to-back dependent instructions behave as if run one
// at a time.
module conditional_alu_with_barrel_shifter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         operation,
  input  logic [3:0]         cond,
  input  logic [3:0]         rd,
  input  logic [3:0]         rn,
  input  logic [11:0]        operand2,
  input  logic               imm_flag,
  input  logic               flag_update,
  input  logic signed [23:0] branch_offset,
  input  logic [31:0]        instr_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               executed,
  output logic               reg_write,
  output logic [3:0]         dest_reg,
  output logic [31:0]        write_value,
  output logic [3:0]         flags_out,
  output logic               branch_taken,
  output logic [31:0]        branch_target
);
  import cawbs_pkg::*;

  item_t dec_item;
  item_t head_item;
  logic  push, q_full, q_valid, q_pop;

  // Front end: handshake and decode.
  cawbs_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .cond          (cond),
    .rd            (rd),
    .rn            (rn),
    .operand2      (operand2),
    .imm_flag      (imm_flag),
    .flag_update   (flag_update),
    .branch_offset (branch_offset),
    .instr_address (instr_address),
    .q_full        (q_full),
    .push          (push),
    .item          (dec_item)
  );

  // Queue that decouples decode from execution.
  cawbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (head_item)
  );

  // Execute side with register file, flags and the output register.
  cawbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .executed      (executed),
    .reg_write     (reg_write),
    .dest_reg      (dest_reg),
    .write_value   (write_value),
    .flags_out     (flags_out),
    .branch_taken  (branch_taken),
    .branch_target (branch_target)
  );

endmodule
